// ===== hdl/jeig3_pkg.sv =====
// ----------------------------------------------------------------------------
// jeig3_pkg
// Shared types, codes and index helpers of the 3x3 Jacobi eigen solver.
// ----------------------------------------------------------------------------
package jeig3_pkg;

	localparam int DIM = 3;
	localparam int NENT = DIM * DIM;

	// configuration register indexes and reset values
	localparam logic CFG_EPSILON = 1'b0;
	localparam logic CFG_MAX_SWEEPS = 1'b1;
	localparam logic [15:0] EPS_RESET = 16'd7;
	localparam logic [3:0] SWEEPS_RESET = 4'd10;

	typedef logic signed [31:0] word_t;

	typedef enum logic [2:0] {
		RD_X1 = 3'd0,
		RD_X2 = 3'd1,
		RD_APP = 3'd2,
		RD_AQQ = 3'd3,
		RD_APQ = 3'd4
	} rd_dst_t;

	typedef enum logic [1:0] {
		DIV_TAU = 2'd0,
		DIV_T30 = 2'd1,
		DIV_C30 = 2'd2
	} div_sel_t;

	typedef enum logic [1:0] {
		MUL_TT = 2'd0,
		MUL_T2 = 2'd1,
		MUL_TC = 2'd2,
		MUL_ROT = 2'd3
	} mul_sel_t;

	typedef enum logic {
		SQ_R = 1'b0,
		SQ_U = 1'b1
	} sqrt_sel_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic clr_max;
		logic rd_en;
		logic rd_vec;
		logic [3:0] rd_idx;
		rd_dst_t rd_dst;
		logic chk;
		logic div_start;
		logic div_take;
		div_sel_t div_sel;
		logic mul_en;
		mul_sel_t mul_sel;
		logic mac_coef_s;
		logic mac_x2;
		logic mac_hi;
		logic mac_acc2;
		logic mac_neg;
		logic sqrt_start;
		logic sqrt_take;
		sqrt_sel_t sqrt_sel;
		logic cs_take;
		logic acc_clr;
		logic wb;
		logic wb_vec;
		logic [3:0] wb_idx1;
		logic [3:0] wb_idx2;
		logic sort;
		logic out_load;
		logic out_conv;
		logic out_last;
		logic [1:0] out_k;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic sqrt_done;
		logic rot_need;
		logic conv;
		logic out_free;
		logic [3:0] max_sweeps;
	} sts_t;

	function automatic logic [1:0] pair_p(input logic [1:0] n);
		pair_p = (n == 2'd2) ? 2'd1 : 2'd0;
	endfunction

	function automatic logic [1:0] pair_q(input logic [1:0] n);
		pair_q = (n == 2'd0) ? 2'd1 : 2'd2;
	endfunction

	function automatic logic [3:0] mat_idx(input logic [1:0] r, input logic [1:0] c);
		mat_idx = {2'd0, r} * 4'd3 + {2'd0, c};
	endfunction

	// entry of an update step: 0..2 rows, 3..5 columns, 6..8 eigenvector columns
	function automatic logic [3:0] ent_idx(input logic [1:0] n, input logic [3:0] ent,
			input logic second);
		logic [1:0] a;
		logic [1:0] k;
		logic row;
		a = second ? pair_q(n) : pair_p(n);
		row = 1'b0;
		case (ent)
			4'd0: begin k = 2'd0; row = 1'b1; end
			4'd1: begin k = 2'd1; row = 1'b1; end
			4'd2: begin k = 2'd2; row = 1'b1; end
			4'd3, 4'd6: k = 2'd0;
			4'd4, 4'd7: k = 2'd1;
			4'd5, 4'd8: k = 2'd2;
			default: k = 2'd0;
		endcase
		ent_idx = row ? mat_idx(a, k) : mat_idx(k, a);
	endfunction

endpackage

// ===== hdl/jeig3_div.sv =====
// ----------------------------------------------------------------------------
// jeig3_div
// Restoring unsigned divider, 64-bit dividend, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jeig3_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [39:0] divisor,
	output logic        done,
	output logic [63:0] quot
);

	logic [63:0] n_q;
	logic [39:0] d_q;
	logic [39:0] rem_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [40:0] rem_sh;
	logic [40:0] diff;

	assign rem_sh = {rem_q, n_q[63]};
	assign diff = rem_sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd63) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= dividend;
			d_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (rem_sh >= {1'b0, d_q}) begin
				rem_q <= diff[39:0];
				n_q <= {n_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh[39:0];
				n_q <= {n_q[62:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = n_q;

endmodule

// ===== hdl/jeig3_sqrt.sv =====
// ----------------------------------------------------------------------------
// jeig3_sqrt
// Integer square root of a 64-bit radicand, one root bit per cycle.
// ----------------------------------------------------------------------------
module jeig3_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] rad,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] v_q;
	logic [63:0] r_q;
	logic [63:0] b_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [63:0] trial;

	assign trial = r_q + b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= rad;
			r_q <= '0;
			b_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[31:0];

endmodule

// ===== hdl/jeig3_dp.sv =====
// ----------------------------------------------------------------------------
// jeig3_dp
// Datapath: matrix and eigenvector files, rotation arithmetic, sort, output.
// ----------------------------------------------------------------------------
module jeig3_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  jeig3_pkg::cmd_t     cmd,
	output jeig3_pkg::sts_t     st,
	input  jeig3_pkg::word_t    mat_in [jeig3_pkg::NENT],
	input  logic                cfg_valid,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [33:0]  eigenvalue,
	output logic signed [17:0]  vec_x,
	output logic signed [17:0]  vec_y,
	output logic signed [17:0]  vec_z,
	output logic                converged,
	output logic                last
);

	logic signed [35:0] work_q [jeig3_pkg::NENT];
	logic signed [17:0] vec_q [jeig3_pkg::NENT];
	logic [15:0] eps_q;
	logic [3:0] sweeps_q;

	logic signed [35:0] x1_q, x2_q, app_q, aqq_q, apq_q;
	logic [35:0] max_q;
	logic [30:0] tmag_q, t30_q, c30_q;
	logic neg_q;
	logic [32:0] d_q;
	logic [31:0] u_q;
	logic signed [27:0] c_q, s_q;
	logic signed [63:0] prod_s1;
	logic mac_s1, mac_acc2_s1, mac_neg_s1, mac_hi_s1;
	logic signed [63:0] acc1_q, acc2_q;
	logic [1:0] ord_q [3];
	logic out_valid_q;

	// ---- operand read port ----
	logic signed [35:0] rd_word;
	always_comb begin
		if (cmd.rd_vec)
			rd_word = {{18{vec_q[cmd.rd_idx][17]}}, vec_q[cmd.rd_idx]};
		else
			rd_word = work_q[cmd.rd_idx];
	end

	// ---- rotation angle terms ----
	logic signed [36:0] num;
	logic [36:0] num_mag;
	logic [35:0] apq_mag;
	assign num = {aqq_q[35], aqq_q} - {app_q[35], app_q};
	assign num_mag = num[36] ? 37'(-num) : 37'(num);
	assign apq_mag = apq_q[35] ? 36'(-apq_q) : 36'(apq_q);

	logic [63:0] div_n;
	logic [39:0] div_d;
	logic div_done;
	logic [63:0] div_q;
	always_comb begin
		case (cmd.div_sel)
			jeig3_pkg::DIV_TAU: begin
				div_n = {11'd0, num_mag, 16'd0};
				div_d = {3'd0, apq_mag, 1'b0};
			end
			jeig3_pkg::DIV_T30: begin
				div_n = 64'h0000_4000_0000_0000 + {32'd0, d_q[32:1]};
				div_d = {7'd0, d_q};
			end
			default: begin
				div_n = 64'h1000_0000_0000_0000 + {33'd0, u_q[31:1]};
				div_d = {8'd0, u_q};
			end
		endcase
	end

	jeig3_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(div_n), .divisor(div_d), .done(div_done), .quot(div_q)
	);

	logic [63:0] sq_rad;
	logic sq_done;
	logic [31:0] sq_root;
	assign sq_rad = (cmd.sqrt_sel == jeig3_pkg::SQ_R) ?
		64'($unsigned(prod_s1)) + 64'h0000_0001_0000_0000 :
		64'($unsigned(prod_s1)) + 64'h1000_0000_0000_0000;

	jeig3_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(cmd.sqrt_start),
		.rad(sq_rad), .done(sq_done), .root(sq_root)
	);

	logic [30:0] tau_sat;
	assign tau_sat = (|div_q[63:31]) ? 31'h7FFF_FFFF : div_q[30:0];

	// ---- shared multiplier ----
	logic signed [31:0] mul_a, mul_b;
	logic signed [35:0] mx;
	assign mx = cmd.mac_x2 ? x2_q : x1_q;
	always_comb begin
		case (cmd.mul_sel)
			jeig3_pkg::MUL_TT: begin
				mul_a = {1'b0, tmag_q};
				mul_b = {1'b0, tmag_q};
			end
			jeig3_pkg::MUL_T2: begin
				mul_a = {1'b0, t30_q};
				mul_b = {1'b0, t30_q};
			end
			jeig3_pkg::MUL_TC: begin
				mul_a = {1'b0, t30_q};
				mul_b = {1'b0, c30_q};
			end
			default: begin
				mul_a = cmd.mac_coef_s ? {{4{s_q[27]}}, s_q} : {{4{c_q[27]}}, c_q};
				mul_b = cmd.mac_hi ? {{14{mx[35]}}, mx[35:18]} : {14'd0, mx[17:0]};
			end
		endcase
	end

	logic signed [63:0] term;
	assign term = mac_hi_s1 ? (prod_s1 <<< 18) : prod_s1;

	logic [31:0] cs_sum;
	logic [31:0] s30_sum;
	logic [60:0] s30_pre;
	assign s30_pre = prod_s1[60:0] + 61'h0000_0000_2000_0000;
	assign s30_sum = {1'b0, s30_pre[60:30]} + 32'd8;
	assign cs_sum = {1'b0, c30_q} + 32'd8;

	// ---- write-back rounding and limits ----
	function automatic logic signed [63:0] round26(input logic signed [63:0] x);
		logic [63:0] m;
		m = x[63] ? 64'(-x) : 64'(x);
		m = (m + 64'h0000_0000_0200_0000) >> 26;
		round26 = x[63] ? 64'(-m) : 64'(m);
	endfunction

	function automatic logic signed [35:0] sat36(input logic signed [63:0] x);
		if (x > 64'sd34359738367)
			sat36 = 36'sh7_FFFF_FFFF;
		else if (x < -64'sd34359738368)
			sat36 = 36'sh8_0000_0000;
		else
			sat36 = x[35:0];
	endfunction

	function automatic logic signed [17:0] sat18(input logic signed [63:0] x);
		if (x > 64'sd65536)
			sat18 = 18'sd65536;
		else if (x < -64'sd65536)
			sat18 = -18'sd65536;
		else
			sat18 = x[17:0];
	endfunction

	function automatic logic signed [33:0] sat34(input logic signed [35:0] x);
		if (x > 36'sd8589934591)
			sat34 = 34'sh1_FFFF_FFFF;
		else if (x < -36'sd8589934592)
			sat34 = 34'sh2_0000_0000;
		else
			sat34 = x[33:0];
	endfunction

	logic signed [63:0] r1, r2;
	assign r1 = round26(acc1_q);
	assign r2 = round26(acc2_q);

	// ---- stable descending order of the diagonal ----
	logic signed [35:0] ev [3];
	logic [1:0] rank [3];
	assign ev[0] = work_q[0];
	assign ev[1] = work_q[4];
	assign ev[2] = work_q[8];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rank[i] = 2'd0;
			for (int j = 0; j < 3; j++) begin
				if (j != i && (ev[j] > ev[i] || (j < i && ev[j] == ev[i])))
					rank[i] = rank[i] + 2'd1;
			end
		end
	end

	logic [1:0] sel;
	logic signed [35:0] diag_sel;
	assign sel = ord_q[cmd.out_k];
	always_comb begin
		case (sel)
			2'd0: diag_sel = work_q[0];
			2'd1: diag_sel = work_q[4];
			default: diag_sel = work_q[8];
		endcase
	end

	// ---- configuration ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= jeig3_pkg::EPS_RESET;
			sweeps_q <= jeig3_pkg::SWEEPS_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == jeig3_pkg::CFG_EPSILON)
				eps_q <= cfg_data;
			else
				sweeps_q <= cfg_data[3:0];
		end
	end

	// ---- control-bearing registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mac_s1 <= cmd.mul_en && (cmd.mul_sel == jeig3_pkg::MUL_ROT);
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < jeig3_pkg::NENT; i++) begin
				work_q[i] <= {{4{mat_in[i][31]}}, mat_in[i]};
				vec_q[i] <= (i == 0 || i == jeig3_pkg::DIM + 1 ||
					i == 2 * (jeig3_pkg::DIM + 1)) ? 18'sd65536 : 18'sd0;
			end
		end else if (cmd.wb) begin
			if (cmd.wb_vec) begin
				vec_q[cmd.wb_idx1] <= sat18(r1);
				vec_q[cmd.wb_idx2] <= sat18(r2);
			end else begin
				work_q[cmd.wb_idx1] <= sat36(r1);
				work_q[cmd.wb_idx2] <= sat36(r2);
			end
		end

		if (cmd.rd_en) begin
			case (cmd.rd_dst)
				jeig3_pkg::RD_X1: x1_q <= rd_word;
				jeig3_pkg::RD_X2: x2_q <= rd_word;
				jeig3_pkg::RD_APP: app_q <= rd_word;
				jeig3_pkg::RD_AQQ: aqq_q <= rd_word;
				default: apq_q <= rd_word;
			endcase
		end

		if (cmd.clr_max)
			max_q <= '0;
		else if (cmd.chk && apq_mag > max_q)
			max_q <= apq_mag;

		if (cmd.div_take) begin
			case (cmd.div_sel)
				jeig3_pkg::DIV_TAU: begin
					tmag_q <= tau_sat;
					neg_q <= (tau_sat != 31'd0) && (num[36] != apq_q[35]);
				end
				jeig3_pkg::DIV_T30: t30_q <= div_q[30:0];
				default: c30_q <= div_q[30:0];
			endcase
		end

		if (cmd.sqrt_take) begin
			if (cmd.sqrt_sel == jeig3_pkg::SQ_R)
				d_q <= {2'd0, tmag_q} + {1'b0, sq_root};
			else
				u_q <= sq_root;
		end

		if (cmd.cs_take) begin
			c_q <= {1'b0, cs_sum[30:4]};
			s_q <= neg_q ? 28'(-{1'b0, s30_sum[30:4]}) : {1'b0, s30_sum[30:4]};
		end

		if (cmd.mul_en)
			prod_s1 <= 64'(mul_a * mul_b);
		mac_acc2_s1 <= cmd.mac_acc2;
		mac_neg_s1 <= cmd.mac_neg;
		mac_hi_s1 <= cmd.mac_hi;

		if (cmd.acc_clr) begin
			acc1_q <= '0;
			acc2_q <= '0;
		end else if (mac_s1) begin
			if (mac_acc2_s1)
				acc2_q <= acc2_q + term;
			else if (mac_neg_s1)
				acc1_q <= acc1_q - term;
			else
				acc1_q <= acc1_q + term;
		end

		if (cmd.sort) begin
			for (int i = 0; i < 3; i++)
				ord_q[rank[i]] <= 2'(i);
		end

		if (cmd.out_load) begin
			converged <= cmd.out_conv;
			last <= cmd.out_last;
			if (cmd.out_conv) begin
				eigenvalue <= sat34(diag_sel);
				vec_x <= vec_q[{2'd0, sel}];
				vec_y <= vec_q[4'd3 + {2'd0, sel}];
				vec_z <= vec_q[4'd6 + {2'd0, sel}];
			end else begin
				eigenvalue <= '0;
				vec_x <= '0;
				vec_y <= '0;
				vec_z <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		st.div_done = div_done;
		st.sqrt_done = sq_done;
		st.rot_need = apq_mag > {20'd0, eps_q};
		st.conv = max_q < {20'd0, eps_q};
		st.out_free = !out_valid_q || out_ready;
		st.max_sweeps = sweeps_q;
	end

endmodule

// ===== hdl/jeig3_ctrl.sv =====
// ----------------------------------------------------------------------------
// jeig3_ctrl
// Sequencer: sweeps, pair tests, rotation steps, sort and result transfers.
// ----------------------------------------------------------------------------
module jeig3_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  jeig3_pkg::sts_t st,
	output jeig3_pkg::cmd_t cmd
);

	typedef enum logic [29:0] {
		S_IDLE      = 30'h0000_0001,
		S_SW_INIT   = 30'h0000_0002,
		S_RD_APQ    = 30'h0000_0004,
		S_CHK       = 30'h0000_0008,
		S_RD_APP    = 30'h0000_0010,
		S_RD_AQQ    = 30'h0000_0020,
		S_DIV_TAU   = 30'h0000_0040,
		S_WAIT_TAU  = 30'h0000_0080,
		S_MUL_TT    = 30'h0000_0100,
		S_SQ_R      = 30'h0000_0200,
		S_WAIT_R    = 30'h0000_0400,
		S_DIV_T     = 30'h0000_0800,
		S_WAIT_T    = 30'h0000_1000,
		S_MUL_T2    = 30'h0000_2000,
		S_SQ_U      = 30'h0000_4000,
		S_WAIT_U    = 30'h0000_8000,
		S_DIV_C     = 30'h0001_0000,
		S_WAIT_C    = 30'h0002_0000,
		S_MUL_TC    = 30'h0004_0000,
		S_CS        = 30'h0008_0000,
		S_ROT_RD1   = 30'h0010_0000,
		S_ROT_RD2   = 30'h0020_0000,
		S_ROT_MAC   = 30'h0040_0000,
		S_ROT_FLUSH = 30'h0080_0000,
		S_ROT_WB    = 30'h0100_0000,
		S_NEXT_PAIR = 30'h0200_0000,
		S_SW_END    = 30'h0400_0000,
		S_SORT      = 30'h0800_0000,
		S_EMIT      = 30'h1000_0000,
		S_GIVEUP    = 30'h2000_0000
	} state_t;

	state_t state_q, nxt;
	logic [1:0] n_q;
	logic [3:0] ent_q;
	logic [2:0] step_q;
	logic [3:0] sweep_q;
	logic [1:0] k_q;
	logic [1:0] p, q;

	assign p = jeig3_pkg::pair_p(n_q);
	assign q = jeig3_pkg::pair_q(n_q);
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					nxt = (st.max_sweeps == 4'd0) ? S_GIVEUP : S_SW_INIT;
				end
			end
			S_SW_INIT: begin
				cmd.clr_max = 1'b1;
				nxt = S_RD_APQ;
			end
			S_RD_APQ: begin
				cmd.rd_en = 1'b1;
				cmd.rd_idx = jeig3_pkg::mat_idx(p, q);
				cmd.rd_dst = jeig3_pkg::RD_APQ;
				nxt = S_CHK;
			end
			S_CHK: begin
				cmd.chk = 1'b1;
				nxt = st.rot_need ? S_RD_APP : S_NEXT_PAIR;
			end
			S_RD_APP: begin
				cmd.rd_en = 1'b1;
				cmd.rd_idx = jeig3_pkg::mat_idx(p, p);
				cmd.rd_dst = jeig3_pkg::RD_APP;
				nxt = S_RD_AQQ;
			end
			S_RD_AQQ: begin
				cmd.rd_en = 1'b1;
				cmd.rd_idx = jeig3_pkg::mat_idx(q, q);
				cmd.rd_dst = jeig3_pkg::RD_AQQ;
				nxt = S_DIV_TAU;
			end
			S_DIV_TAU: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = jeig3_pkg::DIV_TAU;
				nxt = S_WAIT_TAU;
			end
			S_WAIT_TAU: begin
				cmd.div_sel = jeig3_pkg::DIV_TAU;
				if (st.div_done) begin
					cmd.div_take = 1'b1;
					nxt = S_MUL_TT;
				end
			end
			S_MUL_TT: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = jeig3_pkg::MUL_TT;
				nxt = S_SQ_R;
			end
			S_SQ_R: begin
				cmd.sqrt_start = 1'b1;
				cmd.sqrt_sel = jeig3_pkg::SQ_R;
				nxt = S_WAIT_R;
			end
			S_WAIT_R: begin
				cmd.sqrt_sel = jeig3_pkg::SQ_R;
				if (st.sqrt_done) begin
					cmd.sqrt_take = 1'b1;
					nxt = S_DIV_T;
				end
			end
			S_DIV_T: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = jeig3_pkg::DIV_T30;
				nxt = S_WAIT_T;
			end
			S_WAIT_T: begin
				cmd.div_sel = jeig3_pkg::DIV_T30;
				if (st.div_done) begin
					cmd.div_take = 1'b1;
					nxt = S_MUL_T2;
				end
			end
			S_MUL_T2: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = jeig3_pkg::MUL_T2;
				nxt = S_SQ_U;
			end
			S_SQ_U: begin
				cmd.sqrt_start = 1'b1;
				cmd.sqrt_sel = jeig3_pkg::SQ_U;
				nxt = S_WAIT_U;
			end
			S_WAIT_U: begin
				cmd.sqrt_sel = jeig3_pkg::SQ_U;
				if (st.sqrt_done) begin
					cmd.sqrt_take = 1'b1;
					nxt = S_DIV_C;
				end
			end
			S_DIV_C: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = jeig3_pkg::DIV_C30;
				nxt = S_WAIT_C;
			end
			S_WAIT_C: begin
				cmd.div_sel = jeig3_pkg::DIV_C30;
				if (st.div_done) begin
					cmd.div_take = 1'b1;
					nxt = S_MUL_TC;
				end
			end
			S_MUL_TC: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = jeig3_pkg::MUL_TC;
				nxt = S_CS;
			end
			S_CS: begin
				cmd.cs_take = 1'b1;
				nxt = S_ROT_RD1;
			end
			S_ROT_RD1: begin
				cmd.rd_en = 1'b1;
				cmd.rd_vec = (ent_q >= 4'd6);
				cmd.rd_idx = jeig3_pkg::ent_idx(n_q, ent_q, 1'b0);
				cmd.rd_dst = jeig3_pkg::RD_X1;
				cmd.acc_clr = 1'b1;
				nxt = S_ROT_RD2;
			end
			S_ROT_RD2: begin
				cmd.rd_en = 1'b1;
				cmd.rd_vec = (ent_q >= 4'd6);
				cmd.rd_idx = jeig3_pkg::ent_idx(n_q, ent_q, 1'b1);
				cmd.rd_dst = jeig3_pkg::RD_X2;
				nxt = S_ROT_MAC;
			end
			S_ROT_MAC: begin
				// c*x1 - s*x2 into acc1, then s*x1 + c*x2 into acc2, low half first
				cmd.mul_en = 1'b1;
				cmd.mul_sel = jeig3_pkg::MUL_ROT;
				cmd.mac_coef_s = step_q[2] ^ step_q[1];
				cmd.mac_x2 = step_q[1];
				cmd.mac_hi = step_q[0];
				cmd.mac_acc2 = step_q[2];
				cmd.mac_neg = !step_q[2] && step_q[1];
				if (step_q == 3'd7)
					nxt = S_ROT_FLUSH;
			end
			S_ROT_FLUSH: nxt = S_ROT_WB;
			S_ROT_WB: begin
				cmd.wb = 1'b1;
				cmd.wb_vec = (ent_q >= 4'd6);
				cmd.wb_idx1 = jeig3_pkg::ent_idx(n_q, ent_q, 1'b0);
				cmd.wb_idx2 = jeig3_pkg::ent_idx(n_q, ent_q, 1'b1);
				nxt = (ent_q == 4'd8) ? S_NEXT_PAIR : S_ROT_RD1;
			end
			S_NEXT_PAIR: nxt = (n_q == 2'd2) ? S_SW_END : S_RD_APQ;
			S_SW_END: begin
				if (st.conv)
					nxt = S_SORT;
				else if ({1'b0, sweep_q} + 5'd1 >= {1'b0, st.max_sweeps})
					nxt = S_GIVEUP;
				else
					nxt = S_SW_INIT;
			end
			S_SORT: begin
				cmd.sort = 1'b1;
				nxt = S_EMIT;
			end
			S_EMIT: begin
				cmd.out_k = k_q;
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_conv = 1'b1;
					cmd.out_last = (k_q == 2'd2);
					if (k_q == 2'd2)
						nxt = S_IDLE;
				end
			end
			S_GIVEUP: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = 1'b1;
					nxt = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q <= '0;
			ent_q <= '0;
			step_q <= '0;
			sweep_q <= '0;
			k_q <= '0;
		end else begin
			state_q <= nxt;
			case (state_q)
				S_IDLE: sweep_q <= '0;
				S_SW_INIT: n_q <= '0;
				S_CS: ent_q <= '0;
				S_ROT_RD2: step_q <= '0;
				S_ROT_MAC: step_q <= step_q + 3'd1;
				S_ROT_WB: ent_q <= ent_q + 4'd1;
				S_NEXT_PAIR: n_q <= n_q + 2'd1;
				S_SW_END: sweep_q <= sweep_q + 4'd1;
				S_SORT: k_q <= '0;
				S_EMIT: begin
					if (st.out_free)
						k_q <= k_q + 2'd1;
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== hdl/jacobi_eigen_3x3_unit.sv =====
// ----------------------------------------------------------------------------
// jacobi_eigen_3x3_unit
// Cyclic Jacobi eigen solver for one symmetric 3x3 Q16.16 matrix at a time.
// ----------------------------------------------------------------------------
// One matrix is taken per input transfer, and the block then works on it
// alone until its results are out: three transfers (eigenvalues in
// descending order, stable for equal values, each with its eigenvector
// column, converged high, last on the third) or a single give-up transfer
// with all data zero, converged low and last high. Each sweep visits the
// pairs (0,1), (0,2), (1,2); a rotation takes three bit-serial divisions,
// two bit-serial square roots and 9 entry-pair updates on the one shared
// 32x32 multiplier. An item takes up to max_sweeps sweeps plus the sort
// and the result transfers. Configuration writes (index 0 epsilon, index 1
// max_sweeps) are always taken and belong in idle time only; there is no
// clearing pass.
// ----------------------------------------------------------------------------
module jacobi_eigen_3x3_unit (
	input  logic                clk,
	input  logic                arst_n,
	// configuration channel
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data,
	// matrix channel, row-major
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  a00,
	input  logic signed [31:0]  a01,
	input  logic signed [31:0]  a02,
	input  logic signed [31:0]  a10,
	input  logic signed [31:0]  a11,
	input  logic signed [31:0]  a12,
	input  logic signed [31:0]  a20,
	input  logic signed [31:0]  a21,
	input  logic signed [31:0]  a22,
	// result channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [33:0]  eigenvalue,
	output logic signed [17:0]  vec_x,
	output logic signed [17:0]  vec_y,
	output logic signed [17:0]  vec_z,
	output logic                converged,
	output logic                last
);

	jeig3_pkg::cmd_t cmd;
	jeig3_pkg::sts_t st;
	jeig3_pkg::word_t mat_in [jeig3_pkg::NENT];

	// registers are plain flops, a write transfer never stalls
	assign cfg_ready = 1'b1;

	assign mat_in[0] = a00;
	assign mat_in[1] = a01;
	assign mat_in[2] = a02;
	assign mat_in[3] = a10;
	assign mat_in[4] = a11;
	assign mat_in[5] = a12;
	assign mat_in[6] = a20;
	assign mat_in[7] = a21;
	assign mat_in[8] = a22;

	// sequencer: owns in_ready, sweep/pair/entry counters
	jeig3_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.st(st), .cmd(cmd)
	);

	// datapath: matrix files, divider, square root, multiplier, output register
	jeig3_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .st(st), .mat_in(mat_in),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.eigenvalue(eigenvalue), .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.converged(converged), .last(last)
	);

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 3x3 Jacobi eigen solver: a bit-exact predictor
// of the sweeps, rotations and sort, checked against every result transfer
// over several epsilon and sweep-limit settings.
// ----------------------------------------------------------------------------
module testbench;

	typedef logic signed [31:0] mat_t [0:8];

	typedef struct {
		logic signed [33:0] ev;
		logic signed [17:0] x;
		logic signed [17:0] y;
		logic signed [17:0] z;
		logic conv;
		logic last;
	} eig_res_t;

	// expected eigen results, built from each accepted matrix
	class eigen_board;
		eig_res_t pending[$];
		int errors;
		longint unsigned eps;
		longint unsigned sweeps;
		longint work[9];
		longint vecs[9];

		function new();
			errors = 0;
			eps = jeig3_pkg::EPS_RESET;
			sweeps = jeig3_pkg::SWEEPS_RESET;
		endfunction

		function void set_reg(logic idx, logic [15:0] v);
			if (idx == jeig3_pkg::CFG_EPSILON)
				eps = v;
			else
				sweeps = v[3:0];
		endfunction

		function longint unsigned mag(longint x);
			return x < 0 ? longint'(-x) : longint'(x);
		endfunction

		function longint unsigned isqrt(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		// Q26 product back to entry scale, half away from zero
		function longint round26(longint x);
			longint unsigned m;
			m = (mag(x) + (64'd1 << 25)) >> 26;
			return x < 0 ? -longint'(m) : longint'(m);
		endfunction

		function longint clip(longint x, longint lo, longint hi);
			return x < lo ? lo : (x > hi ? hi : x);
		endfunction

		function void rotate(int p, int q);
			longint num, apq, c, s, x1, x2;
			longint unsigned tmag, r, d, t30, u, c30, s30;
			bit neg;
			num = work[q*3+q] - work[p*3+p];
			apq = work[p*3+q];
			tmag = (mag(num) << 16) / (mag(apq) * 2);
			if (tmag > 64'd2147483647)
				tmag = 64'd2147483647;
			neg = tmag != 0 && ((num < 0) != (apq < 0));
			r = isqrt(tmag * tmag + (64'd1 << 32));
			d = tmag + r;
			t30 = ((64'd1 << 46) + d / 2) / d;
			u = isqrt((64'd1 << 60) + t30 * t30);
			c30 = ((64'd1 << 60) + u / 2) / u;
			s30 = (t30 * c30 + (64'd1 << 29)) >> 30;
			c = longint'((c30 + 8) >> 4);
			s = longint'((s30 + 8) >> 4);
			if (neg)
				s = -s;
			// rows, then columns of the matrix, then eigenvector columns
			for (int k = 0; k < 3; k++) begin
				x1 = work[p*3+k];
				x2 = work[q*3+k];
				work[p*3+k] = clip(round26(c*x1 - s*x2), -64'sd34359738368, 64'sd34359738367);
				work[q*3+k] = clip(round26(s*x1 + c*x2), -64'sd34359738368, 64'sd34359738367);
			end
			for (int k = 0; k < 3; k++) begin
				x1 = work[k*3+p];
				x2 = work[k*3+q];
				work[k*3+p] = clip(round26(c*x1 - s*x2), -64'sd34359738368, 64'sd34359738367);
				work[k*3+q] = clip(round26(s*x1 + c*x2), -64'sd34359738368, 64'sd34359738367);
			end
			for (int k = 0; k < 3; k++) begin
				x1 = vecs[k*3+p];
				x2 = vecs[k*3+q];
				vecs[k*3+p] = clip(round26(c*x1 - s*x2), -64'sd65536, 64'sd65536);
				vecs[k*3+q] = clip(round26(s*x1 + c*x2), -64'sd65536, 64'sd65536);
			end
		endfunction

		function void note_matrix(mat_t m);
			longint unsigned peak, mg;
			longint ev[3], col[3], a;
			int p, q, i;
			eig_res_t res;
			for (int k = 0; k < 9; k++) begin
				work[k] = m[k];
				vecs[k] = (k % 4 == 0) ? 64'sd65536 : 64'sd0;
			end
			for (longint unsigned sw = 0; sw < sweeps; sw++) begin
				peak = 0;
				for (int n = 0; n < 3; n++) begin
					p = (n == 2) ? 1 : 0;
					q = (n == 0) ? 1 : 2;
					mg = mag(work[p*3+q]);
					if (mg > peak)
						peak = mg;
					if (mg > eps)
						rotate(p, q);
				end
				if (peak < eps) begin
					for (int k = 0; k < 3; k++)
						ev[k] = work[k*3+k];
					// stable insertion sort, descending, columns follow
					for (int j = 1; j < 3; j++) begin
						a = ev[j];
						for (int k = 0; k < 3; k++)
							col[k] = vecs[k*3+j];
						i = j;
						while (i > 0 && ev[i-1] < a) begin
							ev[i] = ev[i-1];
							for (int k = 0; k < 3; k++)
								vecs[k*3+i] = vecs[k*3+i-1];
							i--;
						end
						ev[i] = a;
						for (int k = 0; k < 3; k++)
							vecs[k*3+i] = col[k];
					end
					for (int k = 0; k < 3; k++) begin
						res.ev = 34'(clip(ev[k], -64'sd8589934592, 64'sd8589934591));
						res.x = 18'(vecs[k]);
						res.y = 18'(vecs[3+k]);
						res.z = 18'(vecs[6+k]);
						res.conv = 1'b1;
						res.last = (k == 2);
						pending.insert(pending.size(), res);
					end
					return;
				end
			end
			res.ev = '0;
			res.x = '0;
			res.y = '0;
			res.z = '0;
			res.conv = 1'b0;
			res.last = 1'b1;
			pending.insert(pending.size(), res);
		endfunction

		function void check(eig_res_t got);
			eig_res_t want;
			if (pending.size() == 0) begin
				$error("unexpected result transfer: eigenvalue %0d", got.ev);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.ev !== want.ev) begin
				$error("eigenvalue: expected %0d, got %0d", want.ev, got.ev);
				errors++;
			end
			if (got.x !== want.x) begin
				$error("vec_x: expected %0d, got %0d", want.x, got.x);
				errors++;
			end
			if (got.y !== want.y) begin
				$error("vec_y: expected %0d, got %0d", want.y, got.y);
				errors++;
			end
			if (got.z !== want.z) begin
				$error("vec_z: expected %0d, got %0d", want.z, got.z);
				errors++;
			end
			if (got.conv !== want.conv) begin
				$error("converged: expected %0d, got %0d", want.conv, got.conv);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_valid, cfg_ready, cfg_index;
	logic [15:0] cfg_data;
	logic in_valid, in_ready;
	logic signed [31:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
	logic out_valid, out_ready;
	logic signed [33:0] eigenvalue;
	logic signed [17:0] vec_x, vec_y, vec_z;
	logic converged, last;

	eigen_board board;
	bit calm;	// no idling in the final phase

	jacobi_eigen_3x3_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.a00(a00), .a01(a01), .a02(a02), .a10(a10), .a11(a11), .a12(a12),
		.a20(a20), .a21(a21), .a22(a22),
		.out_valid(out_valid), .out_ready(out_ready),
		.eigenvalue(eigenvalue), .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.converged(converged), .last(last)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// register write; only called with the block idle
	task automatic write_reg(logic idx, logic [15:0] v);
		cfg_index <= idx;
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.set_reg(idx, v);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// offer one matrix and hold it until the transfer; valid left high, except for an occasional random gap when not calm
	task automatic send_matrix(mat_t m);
		{a00, a01, a02} <= {m[0], m[1], m[2]};
		{a10, a11, a12} <= {m[3], m[4], m[5]};
		{a20, a21, a22} <= {m[6], m[7], m[8]};
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_matrix(m);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4))
				@(posedge clk);
		end
	endtask

	function automatic mat_t sym(int d0, int d1, int d2, int o01, int o02, int o12);
		mat_t m;
		m = '{d0, o01, o02, o01, d1, o12, o02, o12, d2};
		return m;
	endfunction

	function automatic int srand(int unsigned span);
		return int'($urandom_range(0, 2 * span)) - int'(span);
	endfunction

	// random matrix: mostly symmetric with mixed scales, some noise
	function automatic mat_t rand_matrix();
		mat_t m;
		int unsigned span;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				span = 1 << $urandom_range(4, 22);
				m = sym(srand(span), srand(span), srand(span),
					srand(span), srand(span), srand(span));
			end
			4, 5: begin
				// near-diagonal, off-diagonal around epsilon
				span = 1 << $urandom_range(8, 24);
				m = sym(srand(span), srand(span), srand(span),
					srand(12), srand(12), srand(12));
			end
			6, 7:
				m = sym($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			default:
				for (int k = 0; k < 9; k++)
					m[k] = $urandom;
		endcase
		return m;
	endfunction

	task automatic wait_drained();
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);
	endtask

	task automatic run_phase(logic [15:0] eps, logic [3:0] lim, int count);
		write_reg(jeig3_pkg::CFG_EPSILON, eps);
		write_reg(jeig3_pkg::CFG_MAX_SWEEPS, {12'd0, lim});
		for (int n = 0; n < count; n++)
			send_matrix(rand_matrix());
		in_valid <= 1'b0;
		@(posedge clk);
		wait_drained();
	endtask

	// result sampling in the active region of the edge: pre-edge values
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check('{eigenvalue, vec_x, vec_y, vec_z, converged, last});
	end

	// receiver: random stalls, one long hold-off to back the block up
	initial begin
		int unsigned cyc;
		cyc = 0;
		out_ready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			cyc++;
			if (cyc == 30000) begin
				out_ready <= 1'b0;
				repeat (9000)
					@(posedge clk);
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 4))
					@(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		#(64'd600_000_000);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		mat_t m;
		board = new();
		calm = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		{a00, a01, a02, a10, a11, a12, a20, a21, a22} = '0;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset settings
		write_reg(jeig3_pkg::CFG_EPSILON, jeig3_pkg::EPS_RESET);
		write_reg(jeig3_pkg::CFG_MAX_SWEEPS, {12'd0, jeig3_pkg::SWEEPS_RESET});
		send_matrix(sym(0, 0, 0, 0, 0, 0));
		send_matrix(sym(65536, 65536, 65536, 0, 0, 0));		// ties keep order
		send_matrix(sym(-65536, 0, 65536, 0, 0, 0));		// ascending diagonal
		send_matrix(sym(131072, 65536, -196608, 32768, -16384, 8192));
		send_matrix(sym(0, 65536, 0, -65536, 0, 65536));		// negative tau
		send_matrix(sym(65536, 65536, 65536, 65536, 65536, 65536));	// zero tau
		send_matrix(sym(0, 0, 0, 7, 0, 0));	// off-diagonal equal to epsilon
		send_matrix(sym(0, 0, 0, 8, 0, 0));
		send_matrix(sym(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
		send_matrix(sym(32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000));
		send_matrix(sym(32'h7fffffff, 32'h80000000, 0,
			32'h7fffffff, 32'h80000000, 32'h7fffffff));
		send_matrix(sym(32'h80000000, 32'h7fffffff, 32'h7fffffff, 1, -1, 1));
		m = '{65536, 1000, 0, -1000, 65536, 5000, 0, 0, -65536};	// asymmetric
		send_matrix(m);
		m = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
		send_matrix(m);
		m = '{32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
			32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555};
		send_matrix(m);
		send_matrix(sym(1 << 20, 2 << 20, 3 << 20, 1 << 19, 1 << 18, 1 << 17));
		in_valid <= 1'b0;
		@(posedge clk);
		wait_drained();

		run_phase(16'd7, 4'd10, 150);
		run_phase(16'd0, 4'd0, 8);		// no sweep at all
		run_phase(16'd65535, 4'd1, 40);
		run_phase(16'd0, 4'd2, 20);		// zero epsilon never converges
		calm = 1'b1;
		run_phase(16'd300, 4'd15, 60);

		repeat (200)
			@(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
